/* hw/rtl/lghps_pkg.sv */
// ============================================================================
// lghps_pkg
// Shared types, constants and arithmetic helpers for the gray-history pixel
// shader.
// ============================================================================
package lghps_pkg;

    localparam int ROWS           = 64;
    localparam int GROUPS_PER_ROW = 36;
    localparam int HIST_DEPTH     = ROWS * GROUPS_PER_ROW;
    localparam int HIST_AW        = $clog2(HIST_DEPTH);
    localparam int PIX_PER_GROUP  = 4;
    localparam int SHADE_W        = 3;
    localparam int HIST_W         = PIX_PER_GROUP * SHADE_W;
    localparam int CHAN_W         = 8;
    localparam int RGB_W          = 3 * CHAN_W;
    localparam int CFG_IDX_W      = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRAYSCALE_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_COLOR       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_COLOR      = 4'd3;

    localparam logic [RGB_W-1:0] OFF_COLOR_RESET = 24'hFF_FFFF;

    // floor(x * RECIP3 >> RECIP3_SH) == floor(x / 3) for x up to 765
    localparam int RECIP3    = 683;
    localparam int RECIP3_SH = 11;

    typedef struct packed {
        logic [5:0] row;
        logic [5:0] column_group;
        logic [3:0] nibble;
    } t_req;

    typedef struct packed {
        logic [RGB_W-1:0] pixel0_rgb;
        logic [RGB_W-1:0] pixel1_rgb;
        logic [RGB_W-1:0] pixel2_rgb;
        logic [RGB_W-1:0] pixel3_rgb;
    } t_rsp;

    // weights 0,1,1,2,1,2,2,3: population count of the shade index
    function automatic logic [1:0] shade_weight(input logic [SHADE_W-1:0] idx);
        return 2'(idx[0]) + 2'(idx[1]) + 2'(idx[2]);
    endfunction

    function automatic logic [SHADE_W-1:0] next_shade(
        input logic [SHADE_W-1:0] prev,
        input logic               pix,
        input logic               gray
    );
        return gray ? {prev[1:0], pix} : {2'b00, pix};
    endfunction

    // off + (on - off) * w / wtop, truncated toward zero; wtop is 3 or 1
    function automatic logic [CHAN_W-1:0] blend_chan(
        input logic [CHAN_W-1:0] on_c,
        input logic [CHAN_W-1:0] off_c,
        input logic [1:0]        w,
        input logic              gray
    );
        logic signed [10:0] d;
        logic signed [10:0] wx;
        logic signed [10:0] p;
        logic        [9:0]  mag;
        logic        [23:0] prod;
        logic        [9:0]  q;
        logic signed [10:0] v;
        d    = $signed({3'b000, on_c}) - $signed({3'b000, off_c});
        wx   = $signed({9'd0, w});
        p    = d * wx;
        mag  = p[10] ? 10'(-p) : 10'(p);
        prod = 24'(mag) * 24'(RECIP3);
        q    = gray ? 10'(prod >> RECIP3_SH) : mag;
        v    = p[10] ? $signed({3'b000, off_c}) - $signed({1'b0, q})
                     : $signed({3'b000, off_c}) + $signed({1'b0, q});
        return v[CHAN_W-1:0];
    endfunction

endpackage

/* hw/rtl/lcd_gray_history_pixel_shader.sv */
// Path: stage 1 (memory read, history update, write-back), stage 2, color blend.
// Throughput: one request per cycle unless the output or the sweep stalls it,
//   limited by the single read and write port of the history memory;
//   forwarding covers back-to-back hits on one word.
// Reset: synchronous, active low; the history memory is then swept to zero, holding
//   display-on requests; a display-off request sweeps it again if it was written.
// ============================================================================
// lcd_gray_history_pixel_shader
// Shades four LCD pixels per request from a per-pixel three-frame history
// kept in an on-chip memory, and blends each shade between two colors.
// ============================================================================
module lcd_gray_history_pixel_shader
    import lghps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RGB_W-1:0]     i_cfg_wdata,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_req,
    // response channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_rsp                 o_rsp
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic             r_gray;
    logic             r_display_on;
    logic [RGB_W-1:0] r_on_color;
    logic [RGB_W-1:0] r_off_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray       <= 1'b0;
            r_display_on <= 1'b0;
            r_on_color   <= '0;
            r_off_color  <= OFF_COLOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRAYSCALE_MODE: r_gray       <= i_cfg_wdata[0];
                CFG_DISPLAY_ON:     r_display_on <= i_cfg_wdata[0];
                CFG_ON_COLOR:       r_on_color   <= i_cfg_wdata;
                CFG_OFF_COLOR:      r_off_color  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage advances when the one after it is
    // empty or advancing, so bubbles close up behind a stalled output.
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_out_v;
    logic en_out, en2, en1;
    logic in_acc;

    // clearing sweep state
    logic               r_clr_pend;
    logic [HIST_AW-1:0] r_clr_addr;
    logic               r_dirty;

    assign en_out = !r_out_v || i_out_ready;
    assign en2    = !r_s2_v || en_out;
    assign en1    = !r_s1_v || en2;

    // hold display-on requests while the sweep runs; display-off requests
    // never touch the memory and may pass
    assign o_in_ready = en1 && !(r_clr_pend && r_display_on);
    assign in_acc     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Address generation for the incoming request
    // ------------------------------------------------------------------
    logic               in_range;
    logic [HIST_AW-1:0] in_addr;

    assign in_range = (int'(i_req.row) < ROWS) && (int'(i_req.column_group) < GROUPS_PER_ROW);
    assign in_addr  = in_range
                    ? HIST_AW'(HIST_AW'(i_req.row) * HIST_AW'(GROUPS_PER_ROW)
                               + HIST_AW'(i_req.column_group))
                    : '0;

    // ------------------------------------------------------------------
    // Stage 1: read data back from memory, build new history, write back
    // ------------------------------------------------------------------
    logic               r_s1_in_range;
    logic [HIST_AW-1:0] r_s1_addr;
    logic [3:0]         r_s1_nibble;
    logic [HIST_W-1:0]  r_rd_data;
    logic               r_fwd;
    logic [HIST_W-1:0]  r_fwd_data;

    logic [HIST_W-1:0]  s1_old;
    logic [HIST_W-1:0]  s1_next;
    logic               wr_item;

    always_comb begin
        s1_old  = r_s1_in_range ? (r_fwd ? r_fwd_data : r_rd_data) : '0;
        s1_next = '0;
        for (int k = 0; k < PIX_PER_GROUP; k++) begin
            // display off: force every shade to zero, which blends to off color
            if (r_display_on) begin
                s1_next[k*SHADE_W +: SHADE_W] =
                    next_shade(s1_old[k*SHADE_W +: SHADE_W], r_s1_nibble[k], r_gray);
            end
        end
    end

    assign wr_item = r_s1_v && en2 && r_s1_in_range && r_display_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en1) begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_in_range <= in_range;
            r_s1_addr     <= in_addr;
            r_s1_nibble   <= i_req.nibble;
            // the memory returns the old word on a same-cycle write: forward
            r_fwd         <= wr_item && (r_s1_addr == in_addr);
            r_fwd_data    <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // History memory: one write port (sweep has priority), one read port
    // ------------------------------------------------------------------
    logic [HIST_W-1:0] mem [HIST_DEPTH];

    always_ff @(posedge i_clk) begin
        if (r_clr_pend) begin
            mem[r_clr_addr] <= '0;
        end else if (wr_item) begin
            mem[r_s1_addr] <= s1_next;
        end
        if (in_acc) begin
            r_rd_data <= mem[in_addr];
        end
    end

    // ------------------------------------------------------------------
    // Clearing sweep: runs after reset, and after a display-off request
    // once the memory holds anything written since the last sweep
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_pend <= 1'b1;
            r_clr_addr <= '0;
            r_dirty    <= 1'b0;
        end else begin
            if (r_clr_pend) begin
                if (int'(r_clr_addr) == HIST_DEPTH - 1) begin
                    r_clr_pend <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end else if (in_acc && !r_display_on && r_dirty) begin
                r_clr_pend <= 1'b1;
                r_clr_addr <= '0;
            end
            if (in_acc && !r_display_on) begin
                r_dirty <= 1'b0;
            end else if (wr_item) begin
                r_dirty <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: hold the shade indexes for the blend
    // ------------------------------------------------------------------
    logic [HIST_W-1:0] r_s2_shade;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_v) begin
            r_s2_shade <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Color blend into the output register
    // ------------------------------------------------------------------
    logic [RGB_W-1:0] pix_rgb [PIX_PER_GROUP];

    always_comb begin
        for (int k = 0; k < PIX_PER_GROUP; k++) begin
            for (int c = 0; c < 3; c++) begin
                pix_rgb[k][c*CHAN_W +: CHAN_W] =
                    blend_chan(r_on_color[c*CHAN_W +: CHAN_W],
                               r_off_color[c*CHAN_W +: CHAN_W],
                               shade_weight(r_s2_shade[k*SHADE_W +: SHADE_W]),
                               r_gray);
            end
        end
    end

    t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s2_v) begin
            r_rsp.pixel0_rgb <= pix_rgb[0];
            r_rsp.pixel1_rgb <= pix_rgb[1];
            r_rsp.pixel2_rgb <= pix_rgb[2];
            r_rsp.pixel3_rgb <= pix_rgb[3];
        end
    end

    assign o_out_valid = r_out_v;
    assign o_rsp       = r_rsp;

`ifndef SYNTHESIS
    // no display-on request may read the memory before the sweep finishes
    a_no_read_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_display_on) |-> !r_clr_pend)
        else $error("display-on request accepted during clearing sweep");

    // sweep and item write never compete for the write port
    a_no_write_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_item |-> !r_clr_pend)
        else $error("history write during clearing sweep");

    // nothing marks the memory dirty while it is being swept
    a_dirty_vs_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_dirty && r_clr_pend))
        else $error("dirty flag set during clearing sweep");

    // a request accepted behind a write to the same word captures the forwarded data
    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && wr_item && r_s1_addr == in_addr) |=> (r_fwd && r_s1_v))
        else $error("forwarding not captured for same-word request");
`endif

endmodule
